// ===== rtl/core/lct_pkg.sv =====
// Shared constants and types for the LRU cache eviction tracker.
package lct_pkg;

  // Key and configuration widths
  localparam int KEY_W  = 32;
  localparam int CAP_W  = 5;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Register map and reset values
  localparam logic [ADDR_W-1:0] REG_CAPACITY = 3'd0;
  localparam logic [CAP_W-1:0]  CAP_RESET    = 5'd16;

  // Status returned by the shared compare unit
  typedef struct packed {
    logic match;  // stored key equals the request key
    logic take;   // scan: rank is at or above the running maximum; age: entry must age
  } unit_res_t;

endpackage

// ===== rtl/core/lct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lct_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/lct_unit.sv =====
// Shared compare unit: key match, one rank comparator and rank increment.
module lct_unit #(
  parameter int RW = 4
) (
  input  logic [lct_pkg::KEY_W-1:0] key,
  input  logic [lct_pkg::KEY_W-1:0] rd_key,
  input  logic [RW-1:0]             rd_rank,
  input  logic [RW-1:0]             best,
  input  logic [RW-1:0]             limit,
  input  logic                      age_mode,
  input  logic                      age_all,
  output lct_pkg::unit_res_t        res,
  output logic [RW-1:0]             rank_inc
);

  logic [RW-1:0] operand;
  logic          rank_lt;

  // Pick the comparator operand: running maximum while scanning, age limit while aging
  assign operand = age_mode ? limit : best;
  assign rank_lt = rd_rank < operand;

  // Drive status and the aged rank
  assign res.match = (rd_key == key);
  assign res.take  = age_mode ? (age_all | rank_lt) : ~rank_lt;
  assign rank_inc  = rd_rank + RW'(1);

endmodule

// ===== rtl/core/lru_cache_eviction_tracker_core.sv =====
// Top level of the LRU cache eviction tracker: sequencer, registers and storage.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | in        | in_valid / in_stall  | key
//  out     | out       | out_valid / out_stall| evicted, evicted_key, hit
//  cfg     | in        | APB psel / penable   | capacity at byte address 0
//
// A request runs from acceptance to a loaded result through a lookup pass and an aging
// pass (one RAM read per filled entry, each pass ending once the last read data is in),
// then the slot write and the result load. An empty cache skips both passes; the next
// request can be taken in the cycle after the load. rst is synchronous, empties the
// cache and returns capacity to 16. A stalled result sits in the output register while
// the next request is taken.
module lru_cache_eviction_tracker_core #(
  parameter int ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [lct_pkg::KEY_W-1:0]  key,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              evicted,
  output logic signed [lct_pkg::KEY_W-1:0]  evicted_key,
  output logic                              hit,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lct_pkg::ADDR_W-1:0]        paddr,
  input  logic [lct_pkg::DATA_W-1:0]        pwdata,
  output logic [lct_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = IW;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = (CW > lct_pkg::CAP_W) ? CW : lct_pkg::CAP_W;
  localparam int WW = lct_pkg::KEY_W + RW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_AGE    = 3'd2;
  localparam logic [2:0] ST_WRITE  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]                 state;
  logic [lct_pkg::CAP_W-1:0]  cap;
  logic [CW-1:0]              fill;
  logic [lct_pkg::KEY_W-1:0]  key_reg;
  logic [CW-1:0]              cnt;
  logic                       pvalid;
  logic [IW-1:0]              pidx;
  logic                       hit_found;
  logic [IW-1:0]              hit_slot;
  logic [RW-1:0]              hit_rank;
  logic [IW-1:0]              lru_slot;
  logic [lct_pkg::KEY_W-1:0]  lru_key;
  logic [RW-1:0]              best;
  logic                       res_ev;

  logic                       in_accept;
  logic                       cfg_write;
  logic [EW-1:0]              cap_ext;
  logic [EW-1:0]              eff_cap;
  logic                       not_full;
  logic                       issue;
  logic                       last;
  logic [IW-1:0]              target;
  logic                       out_load;

  logic                       ram_we;
  logic [IW-1:0]              ram_waddr;
  logic [WW-1:0]              ram_wdata;
  logic [WW-1:0]              ram_rdata;
  logic [lct_pkg::KEY_W-1:0]  rd_key;
  logic [RW-1:0]              rd_rank;

  lct_pkg::unit_res_t         ures;
  logic [RW-1:0]              rank_inc;

  // Handshake terms
  assign in_accept = in_valid & ~in_stall;
  assign in_stall  = rst | (state != ST_IDLE);
  assign out_load  = (state == ST_FINISH) & (~out_valid | ~out_stall);

  // Configuration port
  assign cfg_write = psel & penable & pwrite & pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr == lct_pkg::REG_CAPACITY) ?
                     lct_pkg::DATA_W'(cap) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= lct_pkg::CAP_RESET;
    end else if (cfg_write && paddr == lct_pkg::REG_CAPACITY) begin
      cap <= pwdata[lct_pkg::CAP_W-1:0];
    end
  end

  // Clamp capacity to 1..ENTRIES
  assign cap_ext  = EW'(cap);
  assign eff_cap  = (cap_ext == '0) ? EW'(1) :
                    ((cap_ext > EW'(ENTRIES)) ? EW'(ENTRIES) : cap_ext);
  assign not_full = EW'(fill) < eff_cap;

  // Pass control: issue one read per entry, process its data in the cycle after
  assign issue  = ((state == ST_SCAN) || (state == ST_AGE)) && (cnt < fill);
  assign last   = pvalid && (CW'(pidx) == (fill - CW'(1)));
  assign target = hit_found ? hit_slot : (not_full ? fill[IW-1:0] : lru_slot);

  // Key and rank storage
  lct_ram #(
    .WIDTH (WW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (cnt[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_key  = ram_rdata[WW-1:RW];
  assign rd_rank = ram_rdata[RW-1:0];

  // Shared compare unit
  lct_unit #(
    .RW (RW)
  ) u_unit (
    .key      (key_reg),
    .rd_key   (rd_key),
    .rd_rank  (rd_rank),
    .best     (best),
    .limit    (hit_rank),
    .age_mode (state == ST_AGE),
    .age_all  (~hit_found),
    .res      (ures),
    .rank_inc (rank_inc)
  );

  // RAM write: age entries during the aging pass, then place the request key
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pidx;
    ram_wdata = {rd_key, rank_inc};
    if (state == ST_AGE) begin
      ram_we = pvalid & ures.take;
    end else if (state == ST_WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = target;
      ram_wdata = {key_reg, RW'(0)};
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      cnt       <= '0;
      pvalid    <= 1'b0;
      hit_found <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            key_reg   <= key;
            hit_found <= 1'b0;
            best      <= '0;
            cnt       <= '0;
            pvalid    <= 1'b0;
            state     <= (fill == '0) ? ST_WRITE : ST_SCAN;
          end
        end
        ST_SCAN, ST_AGE: begin
          pvalid <= issue;
          pidx   <= cnt[IW-1:0];
          if (issue) begin
            cnt <= cnt + CW'(1);
          end
          // Lookup pass: record the first match and the oldest entry
          if (state == ST_SCAN && pvalid) begin
            if (ures.match && !hit_found) begin
              hit_found <= 1'b1;
              hit_slot  <= pidx;
              hit_rank  <= rd_rank;
            end
            if (ures.take) begin
              best     <= rd_rank;
              lru_slot <= pidx;
              lru_key  <= rd_key;
            end
          end
          // Last read data is in: no read is issued this cycle
          if (last) begin
            cnt   <= '0;
            state <= (state == ST_SCAN) ? ST_AGE : ST_WRITE;
          end
        end
        ST_WRITE: begin
          res_ev <= ~hit_found & ~not_full;
          if (!hit_found && not_full) begin
            fill <= fill + CW'(1);
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      hit         <= hit_found;
      evicted     <= res_ev;
      evicted_key <= res_ev ? lru_key : '0;
    end
  end

endmodule

// ===== rtl/core/lct_checker.sv =====
// Port-level checks for the LRU cache eviction tracker, bound to the top level.
module lct_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             evicted,
  input logic signed [lct_pkg::KEY_W-1:0] evicted_key,
  input logic                             hit
);

  // One request at a time: an accepted request blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in flight");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("result reports both hit and eviction");

  // Evicted key is zero without an eviction
  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted |-> evicted_key == '0)
    else $error("evicted key nonzero without eviction");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(evicted_key) && $stable(hit)
      && $stable(evicted))
    else $error("stalled result changed");

endmodule

bind lru_cache_eviction_tracker_core lct_checker u_lct_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .evicted     (evicted),
  .evicted_key (evicted_key),
  .hit         (hit)
);

// ===== bench/lru_cache_eviction_tracker_core_tb.sv =====
// Self-checking testbench for the LRU cache eviction tracker core.
module lru_cache_eviction_tracker_core_tb;

  localparam int SLOTS       = 16;
  localparam int ITEM_TARGET = 1750;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 150;
  localparam int PRINT_LIMIT = 100;

  localparam logic [lct_pkg::KEY_W-1:0] KEY_MIN  = 32'h8000_0000;
  localparam logic [lct_pkg::KEY_W-1:0] KEY_MAX  = 32'h7FFF_FFFF;
  localparam logic [lct_pkg::KEY_W-1:0] KEY_ZERO = 32'h0000_0000;
  localparam logic [lct_pkg::KEY_W-1:0] KEY_ONES = 32'hFFFF_FFFF;

  // One expected outcome of a cache access
  typedef struct {
    logic                             evicted;
    logic signed [lct_pkg::KEY_W-1:0] evicted_key;
    logic                             hit;
  } cache_outcome_t;

  // Mirror of the cache contents and the queue of outcomes still due
  class lru_mirror;
    logic [lct_pkg::KEY_W-1:0] held_key [SLOTS];
    logic [4:0]                age_rank [SLOTS];
    int unsigned               fill;
    logic [lct_pkg::CAP_W-1:0] cap_reg;
    cache_outcome_t            outcome_q[$];
    int                        errors;
    int                        results_seen;

    function new();
      fill         = 0;
      cap_reg      = lct_pkg::CAP_RESET;
      errors       = 0;
      results_seen = 0;
      for (int i = 0; i < SLOTS; i++) begin
        held_key[i] = '0;
        age_rank[i] = '0;
      end
    endfunction

    function void set_capacity(logic [lct_pkg::CAP_W-1:0] v);
      cap_reg = v;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    // Age every filled slot whose rank is below limit
    function void age_below(int unsigned limit);
      for (int i = 0; i < fill; i++) begin
        if (age_rank[i] < limit) age_rank[i] = age_rank[i] + 1'b1;
      end
    endfunction

    // Apply one accepted request and queue the outcome it must produce
    function void note_request(logic [lct_pkg::KEY_W-1:0] k);
      cache_outcome_t o;
      int unsigned    eff;
      int unsigned    way;
      int unsigned    oldest;
      bit             found;
      eff = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : cap_reg);
      found = 1'b0;
      way   = 0;
      for (int i = 0; i < fill; i++) begin
        if (!found && held_key[i] == k) begin
          found = 1'b1;
          way   = i;
        end
      end
      o.evicted     = 1'b0;
      o.evicted_key = '0;
      o.hit         = 1'b0;
      if (found) begin
        age_below(age_rank[way]);
        age_rank[way] = '0;
        o.hit = 1'b1;
      end else if (fill < eff) begin
        way = fill;
        age_below(32'hFFFF_FFFF);
        held_key[way] = k;
        age_rank[way] = '0;
        fill++;
      end else begin
        // Evict the slot holding the highest rank, last one wins on ties
        oldest = 0;
        for (int i = 0; i < fill; i++) begin
          if (age_rank[i] >= oldest) begin
            oldest = age_rank[i];
            way    = i;
          end
        end
        o.evicted     = 1'b1;
        o.evicted_key = held_key[way];
        age_below(32'hFFFF_FFFF);
        held_key[way] = k;
        age_rank[way] = '0;
      end
      outcome_q.push_back(o);
    endfunction

    task report(input string msg);
      if (errors < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compare one accepted result with the oldest outcome due
    task check_result(input logic ev, input logic [lct_pkg::KEY_W-1:0] ek, input logic h);
      cache_outcome_t o;
      results_seen++;
      if (outcome_q.size() == 0) begin
        report($sformatf("result with none due: evicted=%b key=%h hit=%b", ev, ek, h));
      end else begin
        o = outcome_q.pop_front();
        if (ev !== o.evicted)
          report($sformatf("result %0d evicted=%b, want %b", results_seen, ev, o.evicted));
        if (ek !== o.evicted_key)
          report($sformatf("result %0d evicted_key=%h, want %h", results_seen, ek,
                           o.evicted_key));
        if (h !== o.hit)
          report($sformatf("result %0d hit=%b, want %b", results_seen, h, o.hit));
      end
    endtask
  endclass

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [lct_pkg::KEY_W-1:0]  key;
  logic                              out_valid;
  logic                              out_stall;
  logic                              evicted;
  logic signed [lct_pkg::KEY_W-1:0]  evicted_key;
  logic                              hit;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [lct_pkg::ADDR_W-1:0]        paddr;
  logic [lct_pkg::DATA_W-1:0]        pwdata;
  logic [lct_pkg::DATA_W-1:0]        prdata;
  logic                              pready;

  lru_mirror mirror;
  bit        calm;
  int        sent;

  lru_cache_eviction_tracker_core #(.ENTRIES(SLOTS)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .key         (key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .evicted     (evicted),
    .evicted_key (evicted_key),
    .hit         (hit),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #15_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_key(input logic [lct_pkg::KEY_W-1:0] k);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    key      <= k;
    do @(posedge clk); while (in_stall);
    mirror.note_request(k);
    sent++;
  endtask

  // Drop valid and wait until every outcome due has come back
  task automatic settle();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (mirror.pending() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
  endtask

  // APB write of the capacity register, upper data bits random, then read it back
  task automatic write_capacity(input logic [lct_pkg::CAP_W-1:0] v);
    logic [lct_pkg::DATA_W-1:0] junk;
    junk     = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lct_pkg::REG_CAPACITY;
    pwdata  <= {junk[lct_pkg::DATA_W-1:lct_pkg::CAP_W], v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mirror.set_capacity(v);
    @(posedge clk);
    if (prdata !== lct_pkg::DATA_W'(v))
      mirror.report($sformatf("capacity read %h, want %h", prdata, v));
  endtask

  // Extremes, hits, shrinking below fill, capacity zero, saturation, single entry
  task automatic run_directed();
    send_key(KEY_MIN);
    send_key(KEY_MAX);
    send_key(KEY_ZERO);
    send_key(KEY_ONES);
    send_key(KEY_MAX);
    send_key(KEY_MIN);
    settle();
    write_capacity(5'd2);
    send_key(32'h0000_0005);
    send_key(KEY_ZERO);
    send_key(KEY_ONES);
    send_key(32'h0000_0005);
    settle();
    write_capacity(5'd0);
    send_key(32'h0000_0009);
    send_key(32'h0000_0009);
    send_key(32'h0000_000A);
    settle();
    write_capacity(5'd31);
    send_key(32'h5555_5555);
    send_key(32'hAAAA_AAAA);
    send_key(32'h5555_5555);
    settle();
    write_capacity(5'd1);
    send_key(32'h0000_000C);
    send_key(32'h0000_000C);
    send_key(32'h0000_000D);
    settle();
  endtask

  // Pick a capacity for the next phase, extremes included
  function automatic logic [lct_pkg::CAP_W-1:0] pick_capacity();
    int r;
    r = $urandom_range(0, 9);
    unique case (r)
      0: return 5'd0;
      1: return 5'd31;
      2: return 5'd16;
      3: return 5'd1;
      4: return lct_pkg::CAP_W'($urandom_range(17, 31));
      default: return lct_pkg::CAP_W'($urandom_range(1, 16));
    endcase
  endfunction

  // Random key, sometimes one of the extremes
  function automatic logic [lct_pkg::KEY_W-1:0] pick_key();
    unique case ($urandom_range(0, 15))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2: return KEY_ZERO;
      3: return KEY_ONES;
      default: return $urandom;
    endcase
  endfunction

  // Phases of accesses drawn from a small key pool so hits and evictions mix
  task automatic run_random();
    logic [lct_pkg::KEY_W-1:0] key_pool[$];
    logic [lct_pkg::CAP_W-1:0] cap;
    int                        eff;
    int                        items;
    int                        psize;
    while (sent < ITEM_TARGET) begin
      cap = pick_capacity();
      write_capacity(cap);
      eff   = (cap == 0) ? 1 : ((cap > SLOTS) ? SLOTS : cap);
      calm  = ($urandom_range(0, 4) == 0);
      psize = eff + $urandom_range(0, 6);
      key_pool.delete();
      for (int i = 0; i < psize; i++) key_pool.push_back(pick_key());
      items = $urandom_range(15, 90);
      for (int i = 0; i < items; i++) begin
        if ($urandom_range(0, 99) < 85)
          send_key(key_pool[$urandom_range(0, psize - 1)]);
        else
          send_key($urandom);
      end
      settle();
    end
    calm = 1'b0;
  endtask

  // Result side: random stall runs plus one long hold-off while requests are offered
  initial begin
    int  run_left;
    int  hold_left;
    bit  run_stall;
    bit  held;
    run_left  = 0;
    hold_left = 0;
    run_stall = 1'b0;
    held      = 1'b0;
    out_stall <= 1'b0;
    wait (mirror != null);
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) mirror.check_result(evicted, evicted_key, hit);
      if (!held && mirror.results_seen >= HOLD_AFTER && in_valid) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_stall = ($urandom_range(0, 2) == 0);
          run_left  = run_stall ? (pick_gap() + 1) : $urandom_range(1, 20);
        end
        run_left--;
        out_stall <= run_stall;
      end
    end
  end

  // Reset, stimulus, drain and verdict
  initial begin
    in_valid  <= 1'b0;
    key       <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    rst       <= 1'b1;
    calm      = 1'b0;
    sent      = 0;
    mirror    = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.pending() != 0)
      mirror.report($sformatf("%0d outcomes never arrived", mirror.pending()));
    if (mirror.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lct_pkg.sv
rtl/core/lct_ram.sv
rtl/core/lct_unit.sv
rtl/core/lru_cache_eviction_tracker_core.sv
rtl/core/lct_checker.sv
bench/lru_cache_eviction_tracker_core_tb.sv
